[hw/rtl/sfce_pkg.sv]
`default_nettype none
package sfce_pkg;

   localparam int SfceSlotsDefault = 16;
   localparam int MaxSlots         = 16;
   localparam int HdrLen           = 32;
   localparam int RangeLen         = 12;
   localparam int BlockLen         = 8;
   localparam int RcWidth          = 17;

   localparam logic [7:0] CharP = 8'h50;
   localparam logic [7:0] CharF = 8'h46;
   localparam logic [7:0] CharS = 8'h53;
   localparam logic [7:0] CharE = 8'h45;
   localparam logic [7:0] CharQ = 8'h51;
   localparam logic [3:0] NibbleMask = 4'hF;

   typedef enum logic [1:0] {
      KIND_VALUE       = 2'd0,
      KIND_BAD_MAGIC   = 2'd1,
      KIND_COMPRESSED  = 2'd2,
      KIND_NO_CHANNELS = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_BLOCKS = 3'd1,
      PH_RANGES = 3'd2,
      PH_PAD    = 3'd3,
      PH_FRAMES = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // one burst of results handed from the parser to the output buffer
   typedef struct packed {
      logic                        load;
      kind_type                    kind;
      logic [4:0]                  count;
      logic [31:0]                 frame;
      logic [7:0]                  step;
      logic [MaxSlots-1:0][7:0]    vals;
   } burst_type;

endpackage
`default_nettype wire

[hw/rtl/sequence_file_channel_extractor.sv]
`default_nettype none
// Sequence file channel extractor. Takes an uncompressed PSEQ/FSEQ file one
// byte per transfer (start_of_file on the first byte restarts the parser),
// checks the header, reads the sparse ranges into up to CHANNEL_SLOTS (max 16)
// slot channels and, at the end of each frame, returns one result per slot,
// last set on the final one. Bad magic, compressed files and an empty mapping
// give a single status result. Each byte is parsed in the cycle it is accepted;
// the results of a frame or status sit in a one-burst output buffer and leave
// one per cycle while rsp_stall is low. A byte that could complete a frame or a
// status is stalled while the previous burst has results left, unless only its
// final one is left and taken in that cycle, so files with fewer channels than
// slots are paced by the output buffer, which returns a result for every slot.
module sequence_file_channel_extractor #(
   parameter int CHANNEL_SLOTS = sfce_pkg::SfceSlotsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_file,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [3:0]       rsp_slot,
   output logic [7:0]       rsp_channel_value,
   output logic [31:0]      rsp_frame_number,
   output logic [7:0]       rsp_step_ms,
   output logic             rsp_last
);
   import sfce_pkg::*;

   burst_type burst;
   logic      free;
   logic      might_emit;
   logic      accept;

   assign req_stall = !free && might_emit;
   assign accept    = req_valid && !req_stall;

   sfce_parser #(
      .CHANNEL_SLOTS(CHANNEL_SLOTS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .start_of_file(req_start_of_file),
      .burst        (burst),
      .might_emit   (might_emit)
   );

   sfce_out_buf u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .burst            (burst),
      .free             (free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_channel_value(rsp_channel_value),
      .rsp_frame_number (rsp_frame_number),
      .rsp_step_ms      (rsp_step_ms),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

[hw/rtl/sfce_parser.sv]
`default_nettype none
module sfce_parser #(
   parameter int CHANNEL_SLOTS = sfce_pkg::SfceSlotsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                start_of_file,
   output sfce_pkg::burst_type      burst,
   output logic                     might_emit
);
   import sfce_pkg::*;

   localparam int MapSlots = (CHANNEL_SLOTS > MaxSlots) ? MaxSlots :
                             ((CHANNEL_SLOTS < 1) ? 1 : CHANNEL_SLOTS);

   phase_type          phase_ff, phase_in;
   logic [RcWidth-1:0] rc_ff, rc_in;
   logic [7:0]         hdr_ff [HdrLen];
   logic [7:0]         rng_ff [RangeLen];
   logic [3:0]         ridx_ff, ridx_in;
   logic [7:0]         rleft_ff, rleft_in;
   logic [31:0]        map_ff [MaxSlots];
   logic [31:0]        map_in [MaxSlots];
   logic [4:0]         filled_ff, filled_in;
   logic [31:0]        chan_ff, chan_in;
   logic [31:0]        frame_ff, frame_in;
   logic [7:0]         cap_ff [MaxSlots];
   logic [7:0]         cap_in [MaxSlots];
   logic               hdr_we, rng_we;

   logic [31:0]        cc, ft, rstart, rcnt;
   logic [11:0]        bc;
   logic [RcWidth-1:0] be, ends, off, ds;
   logic               magic_ok;

   always_comb begin
      cc     = {hdr_ff[13], hdr_ff[12], hdr_ff[11], hdr_ff[10]};
      ft     = {hdr_ff[17], hdr_ff[16], hdr_ff[15], hdr_ff[14]};
      bc     = {hdr_ff[20][3:0] & NibbleMask, hdr_ff[21]};
      be     = RcWidth'(HdrLen) + RcWidth'({bc, 3'b000});
      ends   = be + RcWidth'({hdr_ff[22], 3'b000}) + RcWidth'({hdr_ff[22], 2'b00});
      off    = {1'b0, hdr_ff[5], hdr_ff[4]};
      ds     = (ends < off) ? off : ends;
      rstart = {rng_ff[3], rng_ff[2], rng_ff[1], rng_ff[0]};
      rcnt   = {rng_ff[7], rng_ff[6], rng_ff[5], rng_ff[4]};
      magic_ok = (hdr_ff[0] == CharP || hdr_ff[0] == CharF) && hdr_ff[1] == CharS &&
                 hdr_ff[2] == CharE && hdr_ff[3] == CharQ;
   end

   always_comb begin
      logic [4:0] room;
      logic [4:0] diff;
      logic       do_settle;
      logic       emit_status;
      kind_type   st_kind;

      phase_in  = phase_ff;
      rc_in     = rc_ff;
      ridx_in   = ridx_ff;
      rleft_in  = rleft_ff;
      filled_in = filled_ff;
      chan_in   = chan_ff;
      frame_in  = frame_ff;
      map_in    = map_ff;
      cap_in    = cap_ff;
      hdr_we    = 1'b0;
      rng_we    = 1'b0;
      do_settle   = 1'b0;
      emit_status = 1'b0;
      st_kind     = KIND_VALUE;
      room = 5'd0;
      diff = 5'd0;
      burst = '0;
      burst.step = hdr_ff[18];

      if (accept) begin
         if (start_of_file) begin
            phase_in  = PH_HEADER;
            rc_in     = '0;
            ridx_in   = '0;
            rleft_in  = '0;
            filled_in = '0;
            chan_in   = '0;
            frame_in  = '0;
            for (int s = 0; s < MaxSlots; s++) begin
               map_in[s] = '0;
               cap_in[s] = '0;
            end
         end

         unique case (phase_in)
            PH_HEADER: begin
               hdr_we = 1'b1;
               rc_in  = rc_in + 1'b1;
               if (rc_in == RcWidth'(HdrLen)) begin
                  if (!magic_ok) begin
                     emit_status = 1'b1;
                     st_kind     = KIND_BAD_MAGIC;
                  end else if (hdr_ff[20][7:4] != 4'd0) begin
                     emit_status = 1'b1;
                     st_kind     = KIND_COMPRESSED;
                  end else begin
                     rleft_in  = hdr_ff[22];
                     phase_in  = PH_BLOCKS;
                     do_settle = 1'b1;
                  end
               end
            end
            PH_BLOCKS, PH_PAD: begin
               rc_in     = rc_in + 1'b1;
               do_settle = 1'b1;
            end
            PH_RANGES: begin
               rng_we    = 1'b1;
               rc_in     = rc_in + 1'b1;
               do_settle = 1'b1;
               if (ridx_in == 4'(RangeLen - 1)) begin
                  ridx_in = '0;
                  // channels start..start+cnt-1 go to the next free slots
                  for (int s = 0; s < MapSlots; s++) begin
                     diff = 5'(s) - filled_in;
                     if (5'(s) >= filled_in && {27'd0, diff} < rcnt)
                        map_in[s] = rstart + {27'd0, diff};
                  end
                  room = 5'(MapSlots) - filled_in;
                  if (rcnt >= {27'd0, room}) filled_in = 5'(MapSlots);
                  else filled_in = filled_in + rcnt[4:0];
                  rleft_in = rleft_in - 1'b1;
               end else begin
                  ridx_in = ridx_in + 1'b1;
               end
            end
            PH_FRAMES: begin
               for (int s = 0; s < MapSlots; s++)
                  if (map_in[s] == chan_in && map_in[s] < cc) cap_in[s] = data_byte;
               chan_in = chan_in + 1'b1;
               if (chan_in >= cc) begin
                  burst.load  = 1'b1;
                  burst.kind  = KIND_VALUE;
                  burst.count = 5'(MapSlots);
                  burst.frame = frame_in;
                  for (int s = 0; s < MapSlots; s++)
                     burst.vals[s] = (map_in[s] < cc) ? cap_in[s] : 8'd0;
                  chan_in  = '0;
                  frame_in = frame_in + 1'b1;
                  if (frame_in >= ft) phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         if (do_settle) begin
            if (phase_in == PH_BLOCKS && rc_in >= be) begin
               phase_in = PH_RANGES;
               ridx_in  = '0;
            end
            if (phase_in == PH_RANGES && rleft_in == 8'd0) begin
               if (hdr_ff[22] == 8'd0) begin
                  for (int s = 0; s < MapSlots; s++)
                     if (32'(s) < cc) map_in[s] = 32'(s);
                  filled_in = (cc >= 32'(MapSlots)) ? 5'(MapSlots) : cc[4:0];
               end
               if (filled_in == 5'd0 || cc == 32'd0) begin
                  emit_status = 1'b1;
                  st_kind     = KIND_NO_CHANNELS;
               end else begin
                  phase_in = PH_PAD;
               end
            end
            if (phase_in == PH_PAD && rc_in >= ds) begin
               chan_in  = '0;
               phase_in = (ft == 32'd0) ? PH_DONE : PH_FRAMES;
            end
         end

         if (emit_status) begin
            burst.load  = 1'b1;
            burst.kind  = st_kind;
            burst.count = 5'd1;
            burst.frame = '0;
            burst.vals  = '0;
            phase_in    = PH_DONE;
         end
      end
   end

   // conservative: any step from this state could hand over a burst
   always_comb begin
      might_emit = (phase_ff == PH_HEADER && rc_ff == RcWidth'(HdrLen - 1)) ||
                   phase_ff == PH_BLOCKS || phase_ff == PH_RANGES ||
                   (phase_ff == PH_FRAMES && (chan_ff + 32'd1) >= cc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         rc_ff     <= '0;
         ridx_ff   <= '0;
         rleft_ff  <= '0;
         filled_ff <= '0;
         chan_ff   <= '0;
         frame_ff  <= '0;
         for (int s = 0; s < MaxSlots; s++) begin
            map_ff[s] <= '0;
            cap_ff[s] <= '0;
         end
      end else begin
         phase_ff  <= phase_in;
         rc_ff     <= rc_in;
         ridx_ff   <= ridx_in;
         rleft_ff  <= rleft_in;
         filled_ff <= filled_in;
         chan_ff   <= chan_in;
         frame_ff  <= frame_in;
         map_ff    <= map_in;
         cap_ff    <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) hdr_ff[(start_of_file ? 5'd0 : rc_ff[4:0])] <= data_byte;
      if (rng_we) rng_ff[ridx_ff] <= data_byte;
   end

endmodule
`default_nettype wire

[hw/rtl/sfce_out_buf.sv]
`default_nettype none
module sfce_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sfce_pkg::burst_type burst,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [3:0]               rsp_slot,
   output logic [7:0]               rsp_channel_value,
   output logic [31:0]              rsp_frame_number,
   output logic [7:0]               rsp_step_ms,
   output logic                     rsp_last
);
   import sfce_pkg::*;

   logic [4:0]  left_ff, left_in;
   logic [3:0]  idx_ff, idx_in;
   kind_type    kind_ff;
   logic [31:0] frame_ff;
   logic [7:0]  step_ff;
   logic [7:0]  vals_ff [MaxSlots];
   logic        xfer;

   assign xfer = rsp_valid && !rsp_stall;
   assign free = (left_ff == 5'd0) || (left_ff == 5'd1 && !rsp_stall);

   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      if (xfer) begin
         left_in = left_ff - 1'b1;
         idx_in  = idx_ff + 1'b1;
      end
      if (burst.load) begin
         left_in = burst.count;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         idx_ff  <= '0;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (burst.load) begin
         kind_ff  <= burst.kind;
         frame_ff <= burst.frame;
         step_ff  <= burst.step;
         for (int s = 0; s < MaxSlots; s++) vals_ff[s] <= burst.vals[s];
      end
   end

   assign rsp_valid         = (left_ff != 5'd0);
   assign rsp_kind          = kind_ff;
   assign rsp_slot          = idx_ff;
   assign rsp_channel_value = vals_ff[idx_ff];
   assign rsp_frame_number  = frame_ff;
   assign rsp_step_ms       = step_ff;
   assign rsp_last          = (left_ff == 5'd1);

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import sfce_pkg::*;

   localparam int StallLimit = 2000;
   localparam int ItemBudget = 410;

   typedef struct {
      kind_type    kind;
      logic [3:0]  slot;
      logic [7:0]  value;
      logic [31:0] frame;
      logic [7:0]  step;
      logic        last;
   } channel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_slot;
   logic [7:0]  rsp_channel_value;
   logic [31:0] rsp_frame_number;
   logic [7:0]  rsp_step_ms;
   logic        rsp_last;

   sequence_file_channel_extractor dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parser mirror
   phase_type   pm_phase;
   logic [31:0] pm_bytes_seen;
   logic [7:0]  pm_header [HdrLen];
   logic [7:0]  pm_range [RangeLen];
   logic [7:0]  pm_ranges_left;
   logic [31:0] pm_slot_chan [MaxSlots];
   int          pm_filled;
   logic [31:0] pm_data_start;
   logic [31:0] pm_chan_pos;
   logic [31:0] pm_frame;
   logic [7:0]  pm_capture [MaxSlots];

   channel_result_type expected_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int max_idle = 12;
   int rsp_wait_left = 0;
   int rsp_hold_left = 0;
   int items_sent = 0;
   logic [7:0]  file_bytes[$];
   logic [31:0] range_start[$];
   logic [31:0] range_count[$];

   function automatic logic [31:0] header_word(int i);
      return {pm_header[i+3], pm_header[i+2], pm_header[i+1], pm_header[i]};
   endfunction

   function automatic logic [31:0] block_table_end();
      return HdrLen + {pm_header[20][3:0], pm_header[21]} * BlockLen;
   endfunction

   function automatic void clear_parser();
      pm_phase = PH_HEADER;
      pm_bytes_seen = 0;
      pm_ranges_left = 0;
      pm_filled = 0;
      pm_data_start = 0;
      pm_chan_pos = 0;
      pm_frame = 0;
      foreach (pm_header[i]) pm_header[i] = 8'd0;
      foreach (pm_range[i]) pm_range[i] = 8'd0;
      foreach (pm_slot_chan[i]) pm_slot_chan[i] = 32'd0;
      foreach (pm_capture[i]) pm_capture[i] = 8'd0;
   endfunction

   function automatic void push_status(kind_type k);
      channel_result_type r;
      r = '{k, 4'd0, 8'd0, 32'd0, pm_header[18], 1'b1};
      expected_results.push_back(r);
      pm_phase = PH_DONE;
   endfunction

   function automatic void advance_regions();
      longint i;
      while (1) begin
         case (pm_phase)
            PH_BLOCKS: begin
               if (pm_bytes_seen < block_table_end()) return;
               pm_phase = PH_RANGES;
            end
            PH_RANGES: begin
               if (pm_ranges_left != 0) return;
               if (pm_header[22] == 0)
                  for (i = 0; i < header_word(10) && pm_filled < MaxSlots; i++)
                     pm_slot_chan[pm_filled++] = i[31:0];
               if (pm_filled == 0 || header_word(10) == 0) begin
                  push_status(KIND_NO_CHANNELS);
                  return;
               end
               pm_phase = PH_PAD;
            end
            PH_PAD: begin
               if (pm_bytes_seen < pm_data_start) return;
               pm_chan_pos = 0;
               pm_phase = (header_word(14) == 0) ? PH_DONE : PH_FRAMES;
               return;
            end
            default: return;
         endcase
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic sof);
      logic [31:0] ends, off, cc, idx, first, cnt;
      longint i;
      channel_result_type r;
      if (sof) clear_parser();
      case (pm_phase)
         PH_HEADER: begin
            pm_header[pm_bytes_seen[4:0]] = b;
            pm_bytes_seen++;
            if (pm_bytes_seen < HdrLen) return;
            if (!(pm_header[1] == CharS && pm_header[2] == CharE && pm_header[3] == CharQ
                  && (pm_header[0] == CharP || pm_header[0] == CharF))) begin
               push_status(KIND_BAD_MAGIC);
               return;
            end
            if (pm_header[20][7:4] != 0) begin
               push_status(KIND_COMPRESSED);
               return;
            end
            pm_ranges_left = pm_header[22];
            ends = block_table_end() + pm_header[22] * RangeLen;
            off = {16'd0, pm_header[5], pm_header[4]};
            pm_data_start = (ends < off) ? off : ends;
            pm_phase = PH_BLOCKS;
            advance_regions();
         end
         PH_BLOCKS, PH_PAD: begin
            pm_bytes_seen++;
            advance_regions();
         end
         PH_RANGES: begin
            idx = (pm_bytes_seen - block_table_end()) % RangeLen;
            pm_range[idx[3:0]] = b;
            pm_bytes_seen++;
            if (idx == RangeLen - 1) begin
               first = {pm_range[3], pm_range[2], pm_range[1], pm_range[0]};
               cnt = {pm_range[7], pm_range[6], pm_range[5], pm_range[4]};
               for (i = 0; i < cnt && pm_filled < MaxSlots; i++)
                  pm_slot_chan[pm_filled++] = first + i[31:0];
               pm_ranges_left--;
            end
            advance_regions();
         end
         PH_FRAMES: begin
            cc = header_word(10);
            pm_bytes_seen++;
            for (int s = 0; s < MaxSlots; s++)
               if (pm_slot_chan[s] == pm_chan_pos && pm_slot_chan[s] < cc)
                  pm_capture[s] = b;
            pm_chan_pos++;
            if (pm_chan_pos < cc) return;
            for (int s = 0; s < MaxSlots; s++) begin
               r = '{KIND_VALUE, s[3:0], (pm_slot_chan[s] < cc) ? pm_capture[s] : 8'd0,
                     pm_frame, pm_header[18], s == MaxSlots - 1};
               expected_results.push_back(r);
            end
            pm_chan_pos = 0;
            pm_frame++;
            if (pm_frame >= header_word(14)) pm_phase = PH_DONE;
         end
         default: ;
      endcase
   endfunction

   // result check, receiver pacing and watchdog
   always @(posedge clock) begin
      channel_result_type want;
      logic moved;
      moved = 1'b0;
      if (!reset && req_valid && !req_stall) moved = 1'b1;
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         rsp_wait_left = $urandom_range(max_idle, 0);
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d slot %0d value %0d frame %0d",
                        rsp_kind, rsp_slot, rsp_channel_value, rsp_frame_number);
         end else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind || rsp_slot !== want.slot
                || rsp_channel_value !== want.value || rsp_frame_number !== want.frame
                || rsp_step_ms !== want.step || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected kind %0d slot %0d value %0d frame %0d ",
                            "step %0d last %0d, got %0d %0d %0d %0d %0d %0d"},
                           want.kind, want.slot, want.value, want.frame, want.step,
                           want.last, rsp_kind, rsp_slot, rsp_channel_value,
                           rsp_frame_number, rsp_step_ms, rsp_last);
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall = 1'b1;
         rsp_hold_left--;
      end else if (rsp_wait_left > 0) begin
         rsp_stall = 1'b1;
         rsp_wait_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic sof);
      int gap;
      gap = $urandom_range(max_idle, 0);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data_byte = b;
      req_start_of_file = sof;
      do @(posedge clock); while (req_stall);
      items_sent++;
      predict_byte(b, sof);
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
   endtask

   task automatic put_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
   endtask

   // header, block table, ranges, padding and nframes frames of random data
   task automatic build_file(input logic [31:0] magic, input logic [3:0] comp,
                             input logic [11:0] blocks, input logic [15:0] offset,
                             input logic [31:0] chans, input logic [31:0] frames,
                             input int nframes);
      file_bytes.delete();
      for (int i = 3; i >= 0; i--) file_bytes.push_back(magic[8*i +: 8]);
      file_bytes.push_back(offset[7:0]);
      file_bytes.push_back(offset[15:8]);
      repeat (4) file_bytes.push_back(8'($urandom));
      put_word(chans);
      put_word(frames);
      repeat (2) file_bytes.push_back(8'($urandom));
      file_bytes.push_back({comp, blocks[11:8]});
      file_bytes.push_back(blocks[7:0]);
      file_bytes.push_back(8'(range_start.size()));
      repeat (9) file_bytes.push_back(8'($urandom));
      repeat (blocks * BlockLen) file_bytes.push_back(8'($urandom));
      foreach (range_start[i]) begin
         put_word(range_start[i]);
         put_word(range_count[i]);
         put_word($urandom);
      end
      while (file_bytes.size() < offset) file_bytes.push_back(8'($urandom));
      repeat (nframes * chans) file_bytes.push_back(8'($urandom));
   endtask

   function automatic logic [31:0] magic_word(bit pseq);
      return {pseq ? CharP : CharF, CharS, CharE, CharQ};
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_directed();
      max_idle = 0;
      range_start = {};
      range_count = {};
      build_file(magic_word(0), 4'd0, 12'd0, 16'd0, 32'd3, 32'd2, 2);
      send_file();
      max_idle = 12;
      // bad magic
      build_file({CharF, CharS, CharE, CharE}, 4'd0, 12'd0, 16'd0, 32'd2, 32'd1, 0);
      send_file();
      build_file(magic_word(1), 4'hF, 12'd0, 16'd0, 32'd2, 32'd1, 0);
      send_file();
      build_file(magic_word(0), 4'd0, 12'd0, 16'd0, 32'd0, 32'd1, 0);
      send_file();
      // frame count zero: data bytes produce nothing
      build_file(magic_word(0), 4'd0, 12'd0, 16'd0, 32'd2, 32'd0, 2);
      send_file();
      // huge channel count, cut short by a restart
      build_file(magic_word(1), 4'd0, 12'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      repeat (4) file_bytes.push_back(8'($urandom));
      send_file();
      range_start = {32'hFFFF_FFF0, 32'd18};
      range_count = {32'hFFFF_FFFF, 32'd3};
      build_file(magic_word(0), 4'd0, 12'd0, 16'd0, 32'd20, 32'd1, 1);
      send_file();
      // block count high nibble set; the file is cut inside the block table
      max_idle = 0;
      range_start = {};
      range_count = {};
      build_file(magic_word(1), 4'd0, 12'h100, 16'd0, 32'd2, 32'd1, 1);
      file_bytes = file_bytes[0:39];
      send_file();
   endtask

   task automatic test_random_files();
      int pick, cut;
      do begin
         max_idle = ($urandom_range(3, 0) == 0) ? 0 : 12;
         range_start = {};
         range_count = {};
         repeat ($urandom_range(3, 0)) begin
            range_start.push_back(32'($urandom_range(30, 0)));
            range_count.push_back(32'($urandom_range(8, 0)));
         end
         pick = $urandom_range(9, 0);
         if (pick < 7)
            build_file(magic_word(1'($urandom_range(1, 0))), 4'd0,
                       12'($urandom_range(2, 0)), 16'($urandom_range(90, 0)),
                       32'($urandom_range(24, 1)), 32'($urandom_range(3, 1)), 3);
         else if (pick == 7)
            build_file($urandom, $urandom_range(1, 0) ? 4'd0 : 4'($urandom_range(15, 1)),
                       12'd0, 16'd0, 32'd4, 32'd1, 1);
         else
            build_file(magic_word(1), 4'd0, 12'($urandom_range(2, 0)),
                       16'($urandom_range(90, 0)), 32'($urandom_range(24, 0)),
                       $urandom, 2);
         if (pick == 9) begin
            cut = $urandom_range(file_bytes.size() - 1, 1);
            file_bytes = file_bytes[0:cut];
         end
         send_file();
         // stray bytes between files
         if ($urandom_range(4, 0) == 0)
            repeat ($urandom_range(5, 1)) send_byte(8'($urandom), 1'b0);
      end while (items_sent < ItemBudget);
   endtask

   task automatic test_output_backpressure();
      max_idle = 0;
      range_start = {};
      range_count = {};
      build_file(magic_word(0), 4'd0, 12'd0, 16'd0, 32'd1, 32'd16, 16);
      rsp_hold_left = 200;
      send_file();
      wait_drained();
   endtask

   task automatic test_drain_pause();
      max_idle = 12;
      range_start = {32'd2, 32'd100};
      range_count = {32'd5, 32'd1};
      build_file(magic_word(1), 4'd0, 12'd1, 16'd70, 32'd9, 32'd1, 1);
      send_file();
      wait_drained();
      range_start = {};
      range_count = {};
      build_file(magic_word(0), 4'd0, 12'd0, 16'd0, 32'd2, 32'd1, 1);
      send_file();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      clear_parser();
      test_directed();
      test_output_backpressure();
      test_drain_pause();
      test_random_files();
      wait_drained();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

[sequence_file_channel_extractor.f]
hw/rtl/sfce_pkg.sv
hw/rtl/sfce_parser.sv
hw/rtl/sfce_out_buf.sv
hw/rtl/sequence_file_channel_extractor.sv
verif/testbench.sv
